// ===== hdl/pcg_pkg.sv =====
// PCG32 package: operation codes, controller states and the command and status structs.
// Used by the controller, the datapath and the top level. No dependencies.
`timescale 1ns / 1ps
package pcg_pkg;

   localparam logic [2:0] MODE_RAW    = 3'd0;
   localparam logic [2:0] MODE_RANGE  = 3'd1;
   localparam logic [2:0] MODE_CHANCE = 3'd2;
   localparam logic [2:0] MODE_SEED   = 3'd3;
   localparam logic [2:0] MODE_LOAD   = 3'd4;

   localparam logic [63:0] LCG_MULT    = 64'd6364136223846793005;
   localparam int          XS_SHIFT_A  = 18;
   localparam int          XS_SHIFT_B  = 27;
   localparam int          ROT_SHIFT   = 59;
   localparam int          RETRY_LIMIT = 64;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_THR,
      ST_DRAW,
      ST_MOD,
      ST_FINISH,
      ST_OUT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch a new request beat
      logic mul_start;   // start a 64x64 multiply of the state
      logic mul_step;    // accumulate one partial product
      logic lcg_commit;  // state <= product + increment, keep the word
      logic div_start;   // start the 32-bit divider
      logic div_step;    // one restoring-division bit
      logic seed_load;   // apply seed or load mode
      logic take_thr;    // divider remainder becomes the threshold
      logic set_error;   // flag an error on the result
      logic out_load;    // move the result into the output register
   } pcg_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [2:0] mode;
      logic       empty_range;
      logic       mul_done;
      logic       div_done;
      logic       word_ok;
      logic       retries_out;
   } pcg_status_type;

endpackage

// ===== hdl/pcg_ctrl.sv =====
// PCG32 controller: sequences capture, LCG steps, divisions and result hand-off.
// Depends on pcg_pkg.
`timescale 1ns / 1ps
module pcg_ctrl
   import pcg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic           out_free,
   input  pcg_status_type status,
   output pcg_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   // ST_MUL here doubles as the dispatch cycle; ST_ADD runs the multiplier;
   // ST_MOD first checks the word, then divides it by the range width.
   logic mod_busy_ff, mod_busy_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_MUL; // decided on next cycle from the captured mode
            end
         end
         ST_MUL: begin
            if (status.mode == MODE_RAW || status.mode == MODE_CHANCE) begin
               state_in = ST_ADD;
            end else if (status.mode == MODE_RANGE) begin
               state_in = status.empty_range ? ST_FINISH : ST_THR;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_ADD: begin
            if (status.mul_done) begin
               state_in = (status.mode == MODE_RANGE) ? ST_MOD : ST_FINISH;
            end
         end
         ST_THR: begin
            if (status.div_done) begin
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            state_in = ST_ADD;
         end
         ST_MOD: begin
            // The divider count still shows the threshold divide until the
            // modulo has been started, so only a running modulo can finish.
            if (!status.word_ok) begin
               state_in = status.retries_out ? ST_FINISH : ST_DRAW;
            end else if (mod_busy_ff && status.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_busy_ff <= 1'b0;
      end else begin
         mod_busy_ff <= mod_busy_in;
      end
   end

   always_comb begin
      mod_busy_in = (state_ff == ST_MOD) && status.word_ok;
   end

   always_comb begin
      cmd = '0;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_tvalid;
         end
         ST_MUL: begin
            if (status.mode == MODE_RAW || status.mode == MODE_CHANCE) begin
               cmd.mul_start = 1'b1;
            end else if (status.mode == MODE_RANGE) begin
               cmd.div_start = !status.empty_range;
               cmd.set_error = status.empty_range;
            end else begin
               cmd.seed_load = 1'b1;
            end
         end
         ST_ADD: begin
            cmd.mul_step   = !status.mul_done;
            cmd.lcg_commit = status.mul_done;
         end
         ST_THR: begin
            cmd.div_step = !status.div_done;
            cmd.take_thr = status.div_done;
         end
         ST_DRAW: begin
            cmd.mul_start = 1'b1;
         end
         ST_MOD: begin
            if (status.word_ok) begin
               cmd.div_start = !mod_busy_ff;
               cmd.div_step  = mod_busy_ff && !status.div_done;
            end else begin
               cmd.set_error = status.retries_out;
            end
         end
         ST_OUT: begin
            cmd.out_load = out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== hdl/pcg_datapath.sv =====
// PCG32 datapath: state registers, serial multiplier, XSH-RR output, restoring divider.
// Depends on pcg_pkg.
`timescale 1ns / 1ps
module pcg_datapath
   import pcg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [2:0]          req_mode,
   input  logic [63:0]         req_seed_value,
   input  logic [63:0]         req_sequence_id,
   input  logic [63:0]         req_load_state,
   input  logic [63:0]         req_load_increment,
   input  logic signed [31:0]  req_range_low,
   input  logic signed [31:0]  req_range_high,
   input  logic [32:0]         req_chance_fraction,
   input  pcg_cmd_type         cmd,
   output pcg_status_type      status,
   output logic [31:0]         res_raw_word,
   output logic signed [31:0]  res_range_value,
   output logic                res_hit,
   output logic                res_error,
   output logic [63:0]         res_state_now,
   output logic [63:0]         res_increment_now
);

   logic [2:0]  mode_ff;
   logic [63:0] seed_ff, seq_ff, lst_ff, linc_ff;
   logic signed [31:0] low_ff, high_ff;
   logic [32:0] frac_ff;

   logic [63:0] gen_state_ff, gen_state_in;
   logic [63:0] gen_inc_ff, gen_inc_in;

   // Multiplier: four 16-bit slices of the constant, one per cycle.
   logic [63:0] acc_ff, acc_in;
   logic [63:0] mop_ff;
   logic [2:0]  mcnt_ff, mcnt_in;

   // Divider: 32-bit restoring, one quotient bit per cycle.
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dnd_ff, dnd_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic [31:0] diff;

   logic [31:0] word_ff, word_in;
   logic [31:0] thr_ff;
   logic [6:0]  tries_ff, tries_in;
   logic        err_ff, err_in;

   logic [31:0] xs_word;
   logic [4:0]  rot;
   logic [31:0] xs_rot;

   assign diff = high_ff - low_ff;
   assign rot  = gen_state_ff[63:ROT_SHIFT];
   assign xs_word = 32'(((gen_state_ff >> XS_SHIFT_A) ^ gen_state_ff) >> XS_SHIFT_B);
   assign xs_rot  = (xs_word >> rot) | (xs_word << ((6'd32 - {1'b0, rot}) & 6'h1F));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= req_mode;
         seed_ff <= req_seed_value;
         seq_ff  <= req_sequence_id;
         lst_ff  <= req_load_state;
         linc_ff <= req_load_increment;
         low_ff  <= req_range_low;
         high_ff <= req_range_high;
         frac_ff <= req_chance_fraction;
      end
      if (cmd.mul_start) begin
         mop_ff <= gen_state_ff;
      end
      if (cmd.take_thr) begin
         thr_ff <= rem_ff[31:0];
      end
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      dnd_ff  <= dnd_in;
      word_ff <= word_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_state_ff <= '0;
         gen_inc_ff   <= '0;
         mcnt_ff      <= '0;
         dcnt_ff      <= '0;
         tries_ff     <= '0;
         err_ff       <= 1'b0;
      end else begin
         gen_state_ff <= gen_state_in;
         gen_inc_ff   <= gen_inc_in;
         mcnt_ff      <= mcnt_in;
         dcnt_ff      <= dcnt_in;
         tries_ff     <= tries_in;
         err_ff       <= err_in;
      end
   end

   always_comb begin
      logic [15:0] slice;
      logic [79:0] part;
      gen_state_in = gen_state_ff;
      gen_inc_in   = gen_inc_ff;
      acc_in       = acc_ff;
      mcnt_in      = mcnt_ff;
      word_in      = word_ff;
      tries_in     = tries_ff;
      err_in       = err_ff;
      slice = LCG_MULT[16*mcnt_ff[1:0] +: 16];
      part  = 80'(mop_ff) * 80'(slice);
      if (cmd.capture) begin
         word_in  = '0;
         tries_in = '0;
         err_in   = 1'b0;
      end
      if (cmd.mul_start) begin
         acc_in  = '0;
         mcnt_in = '0;
      end
      if (cmd.mul_step) begin
         acc_in  = acc_ff + 64'(part << (16 * mcnt_ff[1:0]));
         mcnt_in = mcnt_ff + 3'd1;
      end
      if (cmd.lcg_commit) begin
         gen_state_in = acc_ff + gen_inc_ff;
         word_in      = xs_rot;
         tries_in     = tries_ff + 7'd1;
      end
      if (cmd.seed_load) begin
         if (mode_ff == MODE_SEED) begin
            gen_inc_in   = {seq_ff[62:0], 1'b1};
            gen_state_in = {seq_ff[62:0], 1'b1} + seed_ff;
         end else if (mode_ff == MODE_LOAD) begin
            gen_state_in = lst_ff;
            gen_inc_in   = linc_ff;
         end
      end
      if (cmd.set_error) begin
         err_in = 1'b1;
      end
   end

   always_comb begin
      logic [32:0] trial;
      rem_in  = rem_ff;
      dnd_in  = dnd_ff;
      dcnt_in = dcnt_ff;
      trial   = {rem_ff[31:0], dnd_ff[31]} - {1'b0, diff};
      if (cmd.div_start) begin
         rem_in  = '0;
         dcnt_in = '0;
         dnd_in  = (mode_ff == MODE_RANGE && !cmd.seed_load && tries_ff == 7'd0)
                   ? (32'd0 - diff) : word_ff;
      end
      if (cmd.div_step) begin
         if (!trial[32]) begin
            rem_in = trial;
         end else begin
            rem_in = {rem_ff[31:0], dnd_ff[31]};
         end
         dnd_in  = {dnd_ff[30:0], 1'b0};
         dcnt_in = dcnt_ff + 6'd1;
      end
   end

   assign status.mode        = mode_ff;
   assign status.empty_range = !(low_ff < high_ff);
   assign status.mul_done    = (mcnt_ff == 3'd4);
   assign status.div_done    = (dcnt_ff == 6'd32);
   assign status.word_ok     = (word_ff >= thr_ff);
   assign status.retries_out = (tries_ff == 7'(RETRY_LIMIT));

   always_comb begin
      res_raw_word      = '0;
      res_range_value   = '0;
      res_hit           = 1'b0;
      res_error         = err_ff;
      res_state_now     = gen_state_ff;
      res_increment_now = gen_inc_ff;
      case (mode_ff)
         MODE_RAW: begin
            res_raw_word = word_ff;
         end
         MODE_RANGE: begin
            if (!status.empty_range) begin
               res_raw_word = word_ff;
            end
            if (!err_ff) begin
               res_range_value = rem_ff[31:0] + low_ff;
            end
         end
         MODE_CHANCE: begin
            res_raw_word = word_ff;
            res_hit      = ({1'b0, word_ff} < frac_ff);
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== hdl/pcg32_random_generator.sv =====
// Channel | Dir | Beat contents
// req_    | in  | tdata: mode, seed_value, sequence_id, load_state, load_increment,
//         |     |        range_low, range_high, chance_fraction
// rsp_    | out | tdata: raw_word, range_value, hit, error, state_now, increment_now
// One item at a time. Seed and load write the state and increment; raw and chance draws
// run one serial LCG multiply. A range draw adds a threshold divide, a multiply
// per draw and a final modulo divide. Reset clears state and increment; a stalled
// result blocks the next item.
`timescale 1ns / 1ps
module pcg32_random_generator
   import pcg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[2:0], seed_value[66:3], sequence_id[130:67], load_state[194:131],
   // load_increment[258:195], range_low[290:259], range_high[322:291],
   // chance_fraction[355:323], zero fill
   input  logic [359:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // raw_word[31:0], range_value[63:32], hit[64], error[65], state_now[129:66],
   // increment_now[193:130], zero fill
   output logic [199:0] rsp_tdata
);

   pcg_cmd_type    cmd;
   pcg_status_type status;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [199:0]   rsp_data_ff;
   logic [31:0]    raw_word, range_value;
   logic           hit, error;
   logic [63:0]    state_now, increment_now;

   pcg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .out_free   (!rsp_valid_ff || rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcg_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_mode            (req_tdata[2:0]),
      .req_seed_value      (req_tdata[66:3]),
      .req_sequence_id     (req_tdata[130:67]),
      .req_load_state      (req_tdata[194:131]),
      .req_load_increment  (req_tdata[258:195]),
      .req_range_low       (req_tdata[290:259]),
      .req_range_high      (req_tdata[322:291]),
      .req_chance_fraction (req_tdata[355:323]),
      .cmd                 (cmd),
      .status              (status),
      .res_raw_word        (raw_word),
      .res_range_value     (range_value),
      .res_hit             (hit),
      .res_error           (error),
      .res_state_now       (state_now),
      .res_increment_now   (increment_now)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {6'd0, increment_now, state_now, error, hit, range_value, raw_word};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/pcg_checker.sv =====
// Port-level checks for the PCG32 generator, bound to the top level.
// Depends on pcg32_random_generator ports only.
`timescale 1ns / 1ps
module pcg_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [199:0] rsp_tdata
);

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // One item at a time: no new request right after an accepted one.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // Error and hit never appear together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[64] && rsp_tdata[65]))
      else $error("hit and error both set");

   // An error result never carries a range value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[65] |-> rsp_tdata[63:32] == 32'd0)
      else $error("error result carries a range value");

endmodule

bind pcg32_random_generator pcg_checker u_pcg_checker (.*);
